@@ rtl/core/rxs_pkg.sv @@
// Shared types and constants for the record exchange sorter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rxs_pkg;

   // Field widths of one record and of the result channel
   localparam int ID_W       = 31;
   localparam int PRICE_W    = 32;
   localparam int QTY_W      = 31;
   localparam int POS_W      = 6;
   localparam int MC_W       = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   // Register indexes of the control port
   localparam logic [CSR_IDX_W-1:0] CSR_SORT_KEY   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SORT_ORDER = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_COUNT  = 2'd2;

   localparam logic [MC_W-1:0] MAX_COUNT_RESET = 7'd64;

   // One stored record
   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   qty;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   // Sequencer states
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_EMPTY,
      ST_SORT_READ_I,
      ST_SORT_TAKE_I,
      ST_SORT_CMP,
      ST_SORT_PUT,
      ST_OUT_READ,
      ST_OUT_LOAD
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic             mem_we;
      logic             wr_from_cur;
      logic             cur_load;
      logic             out_load;
      logic             out_empty;
      logic             out_last;
      logic             out_ovf;
      logic             sort_key;
      logic             sort_order;
      logic [POS_W-1:0] out_pos;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic swap;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

@@ rtl/core/rxs_channels.sv @@
// Valid/ready channel interfaces for the record and result streams.
// Depends on rxs_pkg for field widths.
`default_nettype none

interface rxs_req_if;
   import rxs_pkg::*;

   logic               valid;
   logic               ready;
   logic [ID_W-1:0]    record_id;
   logic [PRICE_W-1:0] price_fixed;
   logic [QTY_W-1:0]   quantity;
   logic               holds_record;
   logic               is_last;

   modport source (output valid, input ready,
                   output record_id, price_fixed, quantity, holds_record, is_last);
   modport sink   (input valid, output ready,
                   input record_id, price_fixed, quantity, holds_record, is_last);
endinterface

interface rxs_rsp_if;
   import rxs_pkg::*;

   logic               valid;
   logic               ready;
   logic [ID_W-1:0]    out_id;
   logic [PRICE_W-1:0] out_price;
   logic [QTY_W-1:0]   out_quantity;
   logic [POS_W-1:0]   position;
   logic               last_result;
   logic               empty_set;
   logic               overflowed;

   modport source (output valid, input ready,
                   output out_id, out_price, out_quantity, position,
                   last_result, empty_set, overflowed);
   modport sink   (input valid, output ready,
                   input out_id, out_price, out_quantity, position,
                   last_result, empty_set, overflowed);
endinterface

`default_nettype wire

@@ rtl/core/record_exchange_sorter.sv @@
// Top level of the record exchange sorter: channels, control port, controller, datapath.
// Depends on rxs_pkg, rxs_channels (rxs_req_if, rxs_rsp_if), rxs_ctrl, rxs_datapath.
//
//   Channel    Dir   Handshake           Moves
//   req_chan   in    valid/ready         one record (or end marker) per transfer
//   rsp_chan   out   valid/ready         one sorted record (or empty marker) per transfer
//   csr_*      in    csr_we              one register write per cycle, no read-back
//
// Records load back to back in the load state. After the item marked last, n records (n of
// two or more) sort by exchange, one compare per cycle on the single memory read port, plus a
// take and a put step per outer pass. Output reads, then loads results as the register frees.
// Synchronous reset clears the control state only; the record memory is never cleared.
// The result register holds its transfer until taken; loading of the next set starts
// while the final result of a run still waits.
`default_nettype none

module record_exchange_sorter #(
   parameter int MAX_RECORDS = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   rxs_req_if.sink                        req_chan,
   rxs_rsp_if.source                      rsp_chan,
   input  logic                           csr_we,
   input  logic [rxs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rxs_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rxs_pkg::*;

   localparam int IDX_W = $clog2(MAX_RECORDS);
   localparam int CNT_W = $clog2(MAX_RECORDS + 1);

   cmd_type          cmd;
   sts_type          sts;
   logic [IDX_W-1:0] wr_addr;
   logic [IDX_W-1:0] rd_addr;
   rec_type          in_rec;
   rec_type          rsp_rec;

   assign in_rec.id    = req_chan.record_id;
   assign in_rec.price = req_chan.price_fixed;
   assign in_rec.qty   = req_chan.quantity;

   rxs_ctrl #(
      .MAX_RECORDS (MAX_RECORDS),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_chan.valid),
      .req_holds (req_chan.holds_record),
      .req_last  (req_chan.is_last),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr)
   );

   rxs_datapath #(
      .MAX_RECORDS (MAX_RECORDS),
      .IDX_W       (IDX_W)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr),
      .in_rec    (in_rec),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .rsp_valid (rsp_chan.valid),
      .rsp_rec   (rsp_rec),
      .rsp_pos   (rsp_chan.position),
      .rsp_last  (rsp_chan.last_result),
      .rsp_empty (rsp_chan.empty_set),
      .rsp_ovf   (rsp_chan.overflowed)
   );

   assign rsp_chan.out_id       = rsp_rec.id;
   assign rsp_chan.out_price    = rsp_rec.price;
   assign rsp_chan.out_quantity = rsp_rec.qty;

endmodule

`default_nettype wire

@@ rtl/core/rxs_datapath.sv @@
// Datapath: record memory, running exchange candidate, key compare, result register.
// Depends on rxs_pkg; driven by rxs_ctrl through cmd_type and sts_type.
`default_nettype none

module rxs_datapath #(
   parameter int MAX_RECORDS = 64,
   parameter int IDX_W       = 6
) (
   input  logic                     clock,
   input  logic                     reset,
   input  rxs_pkg::cmd_type         cmd,
   input  logic [IDX_W-1:0]         wr_addr,
   input  logic [IDX_W-1:0]         rd_addr,
   input  rxs_pkg::rec_type         in_rec,
   input  logic                     rsp_ready,
   output rxs_pkg::sts_type         sts,
   output logic                     rsp_valid,
   output rxs_pkg::rec_type         rsp_rec,
   output logic [rxs_pkg::POS_W-1:0] rsp_pos,
   output logic                     rsp_last,
   output logic                     rsp_empty,
   output logic                     rsp_ovf
);
   import rxs_pkg::*;

   rec_type          mem [MAX_RECORDS];
   rec_type          rd_data_ff;
   rec_type          cur_ff, cur_in;
   rec_type          wr_data;
   logic [PRICE_W-1:0] key_cur, key_rd;

   rec_type          out_rec_ff, out_rec_in;
   logic [POS_W-1:0] out_pos_ff, out_pos_in;
   logic             out_last_ff, out_last_in;
   logic             out_empty_ff, out_empty_in;
   logic             out_ovf_ff, out_ovf_in;
   logic             out_valid_ff, out_valid_in;

   // Record memory: one write port, one registered read port
   assign wr_data = cmd.wr_from_cur ? cur_ff : in_rec;

   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Compare held candidate against the entry just read
   assign key_cur = cmd.sort_key ? PRICE_W'(cur_ff.qty) : cur_ff.price;
   assign key_rd  = cmd.sort_key ? PRICE_W'(rd_data_ff.qty) : rd_data_ff.price;
   assign sts.swap = cmd.sort_order ? (key_cur < key_rd) : (key_cur > key_rd);

   assign cur_in = cmd.cur_load ? rd_data_ff : cur_ff;

   // Result register; frees up when the downstream takes the transfer
   assign sts.out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      out_rec_in   = out_rec_ff;
      out_pos_in   = out_pos_ff;
      out_last_in  = out_last_ff;
      out_empty_in = out_empty_ff;
      out_ovf_in   = out_ovf_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      if (cmd.out_load) begin
         out_rec_in   = cmd.out_empty ? '0 : rd_data_ff;
         out_pos_in   = cmd.out_pos;
         out_last_in  = cmd.out_last;
         out_empty_in = cmd.out_empty;
         out_ovf_in   = cmd.out_ovf;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      out_rec_ff   <= out_rec_in;
      out_pos_ff   <= out_pos_in;
      out_last_ff  <= out_last_in;
      out_empty_ff <= out_empty_in;
      out_ovf_ff   <= out_ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_rec   = out_rec_ff;
   assign rsp_pos   = out_pos_ff;
   assign rsp_last  = out_last_ff;
   assign rsp_empty = out_empty_ff;
   assign rsp_ovf   = out_ovf_ff;

endmodule

`default_nettype wire

@@ rtl/core/rxs_ctrl.sv @@
// Controller: control registers, load counter and the load/sort/emit sequencer.
// Depends on rxs_pkg; commands rxs_datapath through cmd_type, reads sts_type.
`default_nettype none

module rxs_ctrl #(
   parameter int MAX_RECORDS = 64,
   parameter int IDX_W       = 6,
   parameter int CNT_W       = 7
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [rxs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rxs_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              req_valid,
   input  logic                              req_holds,
   input  logic                              req_last,
   output logic                              req_ready,
   input  rxs_pkg::sts_type                  sts,
   output rxs_pkg::cmd_type                  cmd,
   output logic [IDX_W-1:0]                  wr_addr,
   output logic [IDX_W-1:0]                  rd_addr
);
   import rxs_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] kept_ff, kept_in;
   logic             ovf_ff, ovf_in;
   logic             run_ovf_ff, run_ovf_in;
   logic [IDX_W-1:0] last_idx_ff, last_idx_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic             sort_key_ff, sort_key_in;
   logic             sort_order_ff, sort_order_in;
   logic [MC_W-1:0]  max_count_ff, max_count_in;

   logic             room;
   logic             take_rec;
   logic [CNT_W-1:0] kept_after;
   logic [MC_W-1:0]  kept_ext;
   logic [MC_W-1:0]  run_count;
   logic [IDX_W-1:0] i_next, j_next, k_next;
   logic             k_is_last;

   // Control register writes; unknown indexes drop
   always_comb begin
      sort_key_in   = sort_key_ff;
      sort_order_in = sort_order_ff;
      max_count_in  = max_count_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SORT_KEY:   sort_key_in   = csr_wdata[0];
            CSR_SORT_ORDER: sort_order_in = csr_wdata[0];
            CSR_MAX_COUNT:  max_count_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   // Load bookkeeping and run length
   assign room       = kept_ff < CNT_W'(MAX_RECORDS);
   assign take_rec   = req_holds && room;
   assign kept_after = kept_ff + CNT_W'(take_rec);
   assign kept_ext   = MC_W'(kept_after);
   assign run_count  = (kept_ext < max_count_ff) ? kept_ext : max_count_ff;

   assign i_next    = i_ff + IDX_W'(1);
   assign j_next    = j_ff + IDX_W'(1);
   assign k_next    = k_ff + IDX_W'(1);
   assign k_is_last = k_ff == last_idx_ff;

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      kept_in     = kept_ff;
      ovf_in      = ovf_ff;
      run_ovf_in  = run_ovf_ff;
      last_idx_in = last_idx_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      k_in        = k_ff;
      req_ready   = 1'b0;
      wr_addr     = kept_ff[IDX_W-1:0];
      rd_addr     = i_ff;
      cmd            = '0;
      cmd.sort_key   = sort_key_ff;
      cmd.sort_order = sort_order_ff;
      cmd.out_ovf    = run_ovf_ff;
      cmd.out_pos    = POS_W'(k_ff);
      cmd.out_last   = k_is_last;

      case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               // Store while there is room, flag the drop otherwise
               if (take_rec) begin
                  cmd.mem_we = 1'b1;
                  kept_in    = kept_after;
               end else if (req_holds) begin
                  ovf_in = 1'b1;
               end
               if (req_last) begin
                  run_ovf_in  = ovf_ff || (req_holds && !room);
                  kept_in     = '0;
                  ovf_in      = 1'b0;
                  last_idx_in = IDX_W'(run_count - MC_W'(1));
                  i_in        = '0;
                  k_in        = '0;
                  if (run_count == '0) begin
                     state_in = ST_EMPTY;
                  end else if (run_count == MC_W'(1)) begin
                     state_in = ST_OUT_READ;
                  end else begin
                     state_in = ST_SORT_READ_I;
                  end
               end
            end
         end

         ST_EMPTY: begin
            cmd.out_empty = 1'b1;
            cmd.out_last  = 1'b1;
            cmd.out_pos   = '0;
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_LOAD;
            end
         end

         ST_SORT_READ_I: begin
            rd_addr  = i_ff;
            state_in = ST_SORT_TAKE_I;
         end

         ST_SORT_TAKE_I: begin
            // Hold entry i as the running candidate, fetch j = i + 1
            cmd.cur_load = 1'b1;
            rd_addr      = i_next;
            j_in         = i_next;
            state_in     = ST_SORT_CMP;
         end

         ST_SORT_CMP: begin
            // Exchange on swap: old candidate goes to slot j, entry j becomes candidate
            wr_addr          = j_ff;
            cmd.wr_from_cur  = 1'b1;
            cmd.mem_we       = sts.swap;
            cmd.cur_load     = sts.swap;
            rd_addr          = j_next;
            j_in             = j_next;
            if (j_ff == last_idx_ff) begin
               state_in = ST_SORT_PUT;
            end
         end

         ST_SORT_PUT: begin
            // Settle slot i and prefetch the next candidate
            wr_addr         = i_ff;
            cmd.wr_from_cur = 1'b1;
            cmd.mem_we      = 1'b1;
            rd_addr         = i_next;
            i_in            = i_next;
            if (i_next == last_idx_ff) begin
               state_in = ST_OUT_READ;
            end else begin
               state_in = ST_SORT_TAKE_I;
            end
         end

         ST_OUT_READ: begin
            rd_addr  = k_ff;
            state_in = ST_OUT_LOAD;
         end

         ST_OUT_LOAD: begin
            rd_addr = k_ff;
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               if (k_is_last) begin
                  state_in = ST_LOAD;
               end else begin
                  rd_addr = k_next;
                  k_in    = k_next;
               end
            end
         end

         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         kept_ff       <= '0;
         ovf_ff        <= 1'b0;
         run_ovf_ff    <= 1'b0;
         sort_key_ff   <= 1'b0;
         sort_order_ff <= 1'b0;
         max_count_ff  <= MAX_COUNT_RESET;
      end else begin
         state_ff      <= state_in;
         kept_ff       <= kept_in;
         ovf_ff        <= ovf_in;
         run_ovf_ff    <= run_ovf_in;
         sort_key_ff   <= sort_key_in;
         sort_order_ff <= sort_order_in;
         max_count_ff  <= max_count_in;
      end
   end

   always_ff @(posedge clock) begin
      last_idx_ff <= last_idx_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
   end

endmodule

`default_nettype wire
